// ===== src/fde_pkg.sv =====
// Shared types and constants for the finite-difference extrapolator.
// Used by the difference cells, the top level and the port checker.
package fde_pkg;

   // Field and datapath widths
   localparam int unsigned SAMPLE_W       = 32;
   localparam int unsigned WORD_W         = 64;
   localparam int unsigned MAX_LENGTH_DEF = 32;

   // Word travelling down the chain of difference cells
   typedef struct packed {
      logic              valid;     // slot holds a sample word
      logic              last;      // final sample of the sequence
      logic              absorb;    // sample still updating rows
      logic              overflow;  // sequence went past the table depth
      logic [WORD_W-1:0] value;     // difference handed to the next row
      logic [WORD_W-1:0] acc_next;  // running sum of newest elements
      logic [WORD_W-1:0] acc_prev;  // running alternating sum of first elements
   } token_type;

endpackage

// ===== src/finite_difference_extrapolator.sv =====
// Top level: sample counter, chain of difference cells, result register.
// Depends on fde_pkg and fde_cell.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_stall | req_sample, req_last_of_sequence
//   rsp     | out | rsp_valid/rsp_stall | next/previous value, totals, too_long
//
// One sample word per cycle is accepted while the chain advances; each word walks
// the cell chain, one row per cycle, and its result is then held in the result register.
// Reset is synchronous and clears counters, row fill flags and totals at once.
// A stalled result freezes the whole chain, and req_stall follows it.
module finite_difference_extrapolator #(
   parameter int unsigned MAX_LENGTH = fde_pkg::MAX_LENGTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fde_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last_of_sequence,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fde_pkg::WORD_W-1:0]   rsp_next_value,
   output logic signed [fde_pkg::WORD_W-1:0]   rsp_previous_value,
   output logic signed [fde_pkg::WORD_W-1:0]   rsp_total_next,
   output logic signed [fde_pkg::WORD_W-1:0]   rsp_total_previous,
   output logic                                rsp_too_long
);

   localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);

   logic                       advance;
   logic                       accept;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       overflow_ff, overflow_in;
   logic                       room;
   fde_pkg::token_type         chain [MAX_LENGTH+1];
   fde_pkg::token_type         tail;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [fde_pkg::WORD_W-1:0] next_ff, prev_ff, tot_next_ff, tot_prev_ff;
   logic [fde_pkg::WORD_W-1:0] tot_next_in, tot_prev_in;
   logic                       too_long_ff;
   logic                       finish;

   // Whole chain moves unless a finished result is held by the consumer
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Head: decide whether the sample fits the table
   always_comb begin
      room        = count_ff < CNT_MAX;
      overflow_in = overflow_ff | !room;
      count_in    = count_ff + CNT_W'(room);
      if (req_last_of_sequence) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end

      chain[0].valid    = accept;
      chain[0].last     = req_last_of_sequence;
      chain[0].absorb   = room;
      chain[0].overflow = overflow_ff | !room;
      chain[0].value    = fde_pkg::WORD_W'(req_sample);
      chain[0].acc_next = '0;
      chain[0].acc_prev = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Chain of rows, odd rows subtract in the backward sum
   for (genvar k = 0; k < MAX_LENGTH; k++) begin : g_row
      fde_cell #(
         .NEGATE_FIRST(k % 2 == 1)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .tok_in (chain[k]),
         .tok_out(chain[k+1])
      );
   end

   assign tail = chain[MAX_LENGTH];

   // Result register and running totals
   always_comb begin
      finish       = tail.valid && tail.last;
      rsp_valid_in = finish;
      tot_next_in  = tot_next_ff + tail.acc_next;
      tot_prev_in  = tot_prev_ff + tail.acc_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tot_next_ff  <= '0;
         tot_prev_ff  <= '0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            tot_next_ff <= tot_next_in;
            tot_prev_ff <= tot_prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && finish) begin
         next_ff     <= tail.acc_next;
         prev_ff     <= tail.acc_prev;
         too_long_ff <= tail.overflow;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_value     = next_ff;
   assign rsp_previous_value = prev_ff;
   assign rsp_total_next     = tot_next_ff;
   assign rsp_total_previous = tot_prev_ff;
   assign rsp_too_long       = too_long_ff;

endmodule

// ===== src/fde_cell.sv =====
// One row of the difference table: newest and first element of the row.
// Depends on fde_pkg for the chain word type.
module fde_cell #(
   parameter bit NEGATE_FIRST = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  fde_pkg::token_type tok_in,
   output fde_pkg::token_type tok_out
);

   logic                       filled_ff, filled_in;
   logic [fde_pkg::WORD_W-1:0] newest_ff, newest_in;
   logic [fde_pkg::WORD_W-1:0] first_ff, first_in;
   fde_pkg::token_type         tok_ff, tok_in_next;

   logic upd;
   logic closing;

   // Row update and contribution to the end-of-sequence sums
   always_comb begin
      upd       = tok_in.valid && tok_in.absorb;
      closing   = tok_in.valid && tok_in.last;
      newest_in = upd ? tok_in.value : newest_ff;
      first_in  = (upd && !filled_ff) ? tok_in.value : first_ff;
      filled_in = filled_ff | upd;

      tok_in_next        = tok_in;
      tok_in_next.absorb = upd && filled_ff;
      tok_in_next.value  = tok_in.value - newest_ff;
      if (closing && filled_in) begin
         tok_in_next.acc_next = tok_in.acc_next + newest_in;
         if (NEGATE_FIRST) begin
            tok_in_next.acc_prev = tok_in.acc_prev - first_in;
         end else begin
            tok_in_next.acc_prev = tok_in.acc_prev + first_in;
         end
      end
   end

   // Row fill flag and chain word; of the chain word only the valid bit needs reset
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         filled_ff <= closing ? 1'b0 : filled_in;
         tok_ff    <= tok_in_next;
      end
   end

   // Row contents
   always_ff @(posedge clock) begin
      if (advance) begin
         newest_ff <= newest_in;
         first_ff  <= first_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/fde_checker.sv =====
// Port-level checks for the finite-difference extrapolator.
// Depends on fde_pkg; bound to the top level at the end of this file.
module fde_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [fde_pkg::WORD_W-1:0]   rsp_next_value,
   input logic signed [fde_pkg::WORD_W-1:0]   rsp_previous_value,
   input logic signed [fde_pkg::WORD_W-1:0]   rsp_total_next,
   input logic signed [fde_pkg::WORD_W-1:0]   rsp_total_previous
);

   // Input only backs up when a result is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a held result");

   // A held result keeps its totals
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_next)
                                 && $stable(rsp_total_previous))
      else $error("held result changed");

   // Totals grow by exactly the new values
   a_total_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 rsp_valid
         |-> rsp_total_next == $past(rsp_total_next) + rsp_next_value)
      else $error("next total mismatch");

   a_total_prev: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 rsp_valid
         |-> rsp_total_previous == $past(rsp_total_previous) + rsp_previous_value)
      else $error("previous total mismatch");

   // Reset empties the result register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind finite_difference_extrapolator fde_checker u_fde_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_next_value    (rsp_next_value),
   .rsp_previous_value(rsp_previous_value),
   .rsp_total_next    (rsp_total_next),
   .rsp_total_previous(rsp_total_previous)
);
